FILE: design/box_corner_rotator_assert.svh
// assertion macros for the checker file
`ifndef BOX_CORNER_ROTATOR_ASSERT_SVH
`define BOX_CORNER_ROTATOR_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("box_corner_rotator check failed");

// consequent must hold in the same cycle as the antecedent
`define BRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("box_corner_rotator check failed");

`endif

FILE: design/brc_pkg.sv
package brc_pkg;

    // cordic iteration count, capped at 32
    localparam int SINE_STAGES   = 16;
    localparam int CORDIC_STAGES = (SINE_STAGES > 32) ? 32 : SINE_STAGES;
    localparam int IDX_W         = 5;

    // coordinate and internal widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int XY_W    = 33;
    localparam int Z_W     = 34;
    localparam int ANG_W   = 20;
    localparam int RED_W   = 36;
    localparam int TRIG_W  = 32;
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int RND_W   = SUM_W - 30;
    localparam int FIN_W   = RND_W + 1;
    localparam int CORNERS = 4;

    // angle constants in Q30
    localparam logic signed [RED_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [RED_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [RED_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sh026DD3B6A;
    localparam logic signed [TRIG_W-1:0] Q30_ONE    = 32'sd1073741824;

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_TABLE [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // rotation vector state handed along the cell row
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_cordic;

    // corner offsets from the pivot, plus the pivot itself
    typedef struct packed {
        logic [CORNERS-1:0][DIFF_W-1:0] dx;
        logic [CORNERS-1:0][DIFF_W-1:0] dy;
        logic [COORD_W-1:0]             px;
        logic [COORD_W-1:0]             py;
    } t_geom;

endpackage

FILE: design/brc_prep.sv
module brc_prep (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [brc_pkg::CORNERS-1:0][brc_pkg::COORD_W-1:0] i_cx,
    input  logic [brc_pkg::CORNERS-1:0][brc_pkg::COORD_W-1:0] i_cy,
    input  logic [brc_pkg::COORD_W-1:0]                i_px,
    input  logic [brc_pkg::COORD_W-1:0]                i_py,
    input  logic [brc_pkg::ANG_W-1:0]                  i_angle,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output brc_pkg::t_cordic                           o_cordic,
    output brc_pkg::t_geom                             o_geom
);
    import brc_pkg::*;

    logic                    r_valid;
    t_cordic                 r_cordic;
    t_geom                   r_geom;
    t_cordic                 n_cordic;
    t_geom                   n_geom;
    logic                    take;
    logic signed [RED_W-1:0] z_full;
    logic signed [RED_W-1:0] z_wrap;
    logic signed [RED_W-1:0] z_red;
    logic                    flip;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // angle to Q30, fold into one turn, then into the right half plane
    always_comb begin
        z_full = RED_W'($signed({i_angle, 14'b0}));
        if (z_full > Q30_PI) begin
            z_wrap = z_full - Q30_TWO_PI;
        end else if (z_full < -Q30_PI) begin
            z_wrap = z_full + Q30_TWO_PI;
        end else begin
            z_wrap = z_full;
        end
        if (z_wrap > Q30_HALF_PI) begin
            z_red = z_wrap - Q30_PI;
            flip  = 1'b1;
        end else if (z_wrap < -Q30_HALF_PI) begin
            z_red = z_wrap + Q30_PI;
            flip  = 1'b1;
        end else begin
            z_red = z_wrap;
            flip  = 1'b0;
        end
        n_cordic.x    = CORDIC_GAIN;
        n_cordic.y    = '0;
        n_cordic.z    = Z_W'(z_red);
        n_cordic.flip = flip;
    end

    // corner offsets from the pivot, one bit wider
    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            n_geom.dx[k] = DIFF_W'($signed({i_cx[k][COORD_W-1], i_cx[k]})
                                 - $signed({i_px[COORD_W-1], i_px}));
            n_geom.dy[k] = DIFF_W'($signed({i_cy[k][COORD_W-1], i_cy[k]})
                                 - $signed({i_py[COORD_W-1], i_py}));
        end
        n_geom.px = i_px;
        n_geom.py = i_py;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // word register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cordic <= n_cordic;
            r_geom   <= n_geom;
        end
    end

    assign o_valid  = r_valid;
    assign o_cordic = r_cordic;
    assign o_geom   = r_geom;

endmodule

FILE: design/brc_cell.sv
module brc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [brc_pkg::IDX_W-1:0]  i_shift,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  brc_pkg::t_cordic           i_cordic,
    input  brc_pkg::t_geom             i_geom,
    output logic                       o_valid,
    input  logic                       i_ready,
    output brc_pkg::t_cordic           o_cordic,
    output brc_pkg::t_geom             o_geom
);
    import brc_pkg::*;

    logic                   r_valid;
    t_cordic                r_cordic;
    t_geom                  r_geom;
    t_cordic                n_cordic;
    logic                   take;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  step_ang;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // one micro-rotation, direction from the sign of the residual angle
    assign x_sh     = i_cordic.x >>> i_shift;
    assign y_sh     = i_cordic.y >>> i_shift;
    assign step_ang = Z_W'(ATAN_TABLE[i_shift]);

    always_comb begin
        n_cordic.flip = i_cordic.flip;
        if (i_cordic.z >= 0) begin
            n_cordic.x = i_cordic.x - y_sh;
            n_cordic.y = i_cordic.y + x_sh;
            n_cordic.z = i_cordic.z - step_ang;
        end else begin
            n_cordic.x = i_cordic.x + y_sh;
            n_cordic.y = i_cordic.y - x_sh;
            n_cordic.z = i_cordic.z + step_ang;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // word register, geometry rides along
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cordic <= n_cordic;
            r_geom   <= i_geom;
        end
    end

    assign o_valid  = r_valid;
    assign o_cordic = r_cordic;
    assign o_geom   = r_geom;

endmodule

FILE: design/brc_rotate.sv
module brc_rotate (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  brc_pkg::t_cordic                                  i_cordic,
    input  brc_pkg::t_geom                                    i_geom,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic [brc_pkg::CORNERS-1:0][brc_pkg::COORD_W-1:0] o_x,
    output logic [brc_pkg::CORNERS-1:0][brc_pkg::COORD_W-1:0] o_y
);
    import brc_pkg::*;

    // trig stage
    logic                     r_t_valid;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    t_geom                    r_t_geom;
    logic signed [XY_W:0]     cos_full;
    logic signed [XY_W:0]     sin_full;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] n_sin;

    // product stage
    logic                     r_m_valid;
    logic signed [PROD_W-1:0] r_dxc [CORNERS];
    logic signed [PROD_W-1:0] r_dys [CORNERS];
    logic signed [PROD_W-1:0] r_dxs [CORNERS];
    logic signed [PROD_W-1:0] r_dyc [CORNERS];
    logic [COORD_W-1:0]       r_m_px;
    logic [COORD_W-1:0]       r_m_py;

    // output stage
    logic                     r_s_valid;
    logic [CORNERS-1:0][COORD_W-1:0] r_x;
    logic [CORNERS-1:0][COORD_W-1:0] r_y;
    logic [CORNERS-1:0][COORD_W-1:0] n_x;
    logic [CORNERS-1:0][COORD_W-1:0] n_y;

    logic rdy_t;
    logic rdy_m;
    logic rdy_s;

    // ready ripples back from the output register
    assign rdy_s   = !r_s_valid || i_ready;
    assign rdy_m   = !r_m_valid || rdy_s;
    assign rdy_t   = !r_t_valid || rdy_m;
    assign o_ready = rdy_t;

    // undo the half-turn fold and clamp to plus or minus one
    always_comb begin
        cos_full = i_cordic.flip ? -(XY_W+1)'(i_cordic.x) : (XY_W+1)'(i_cordic.x);
        sin_full = i_cordic.flip ? -(XY_W+1)'(i_cordic.y) : (XY_W+1)'(i_cordic.y);
        if (cos_full > (XY_W+1)'(Q30_ONE)) begin
            n_cos = Q30_ONE;
        end else if (cos_full < -(XY_W+1)'(Q30_ONE)) begin
            n_cos = -Q30_ONE;
        end else begin
            n_cos = TRIG_W'(cos_full);
        end
        if (sin_full > (XY_W+1)'(Q30_ONE)) begin
            n_sin = Q30_ONE;
        end else if (sin_full < -(XY_W+1)'(Q30_ONE)) begin
            n_sin = -Q30_ONE;
        end else begin
            n_sin = TRIG_W'(sin_full);
        end
    end

    // round half up to Q16.16, add the pivot back, saturate
    always_comb begin
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] rnd_x;
        logic signed [SUM_W-1:0] rnd_y;
        logic signed [FIN_W-1:0] fin_x;
        logic signed [FIN_W-1:0] fin_y;
        for (int k = 0; k < CORNERS; k++) begin
            sum_x = SUM_W'(r_dxc[k]) - SUM_W'(r_dys[k]) + SUM_W'(64'sd536870912);
            sum_y = SUM_W'(r_dxs[k]) + SUM_W'(r_dyc[k]) + SUM_W'(64'sd536870912);
            rnd_x = sum_x >>> 30;
            rnd_y = sum_y >>> 30;
            fin_x = FIN_W'(rnd_x) + FIN_W'($signed(r_m_px));
            fin_y = FIN_W'(rnd_y) + FIN_W'($signed(r_m_py));
            if (fin_x > FIN_W'(64'sd2147483647)) begin
                n_x[k] = 32'h7FFF_FFFF;
            end else if (fin_x < FIN_W'(-64'sd2147483648)) begin
                n_x[k] = 32'h8000_0000;
            end else begin
                n_x[k] = COORD_W'(fin_x);
            end
            if (fin_y > FIN_W'(64'sd2147483647)) begin
                n_y[k] = 32'h7FFF_FFFF;
            end else if (fin_y < FIN_W'(-64'sd2147483648)) begin
                n_y[k] = 32'h8000_0000;
            end else begin
                n_y[k] = COORD_W'(fin_y);
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (rdy_t) begin
                r_t_valid <= i_valid;
            end
            if (rdy_m) begin
                r_m_valid <= r_t_valid;
            end
            if (rdy_s) begin
                r_s_valid <= r_m_valid;
            end
        end
    end

    // trig register
    always_ff @(posedge i_clk) begin
        if (i_valid && rdy_t) begin
            r_cos    <= n_cos;
            r_sin    <= n_sin;
            r_t_geom <= i_geom;
        end
    end

    // product registers, one multiplier per product
    always_ff @(posedge i_clk) begin
        if (r_t_valid && rdy_m) begin
            for (int k = 0; k < CORNERS; k++) begin
                r_dxc[k] <= $signed(r_t_geom.dx[k]) * r_cos;
                r_dys[k] <= $signed(r_t_geom.dy[k]) * r_sin;
                r_dxs[k] <= $signed(r_t_geom.dx[k]) * r_sin;
                r_dyc[k] <= $signed(r_t_geom.dy[k]) * r_cos;
            end
            r_m_px <= r_t_geom.px;
            r_m_py <= r_t_geom.py;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_m_valid && rdy_s) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_valid = r_s_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

FILE: design/box_corner_rotator.sv
// Rotates the four corners of a box about a pivot point.
// Input channel: i_in_valid / o_in_ready carry one word: four corners and
// the pivot in signed Q16.16 plus the turn angle in signed Q4.16 radians.
// Output channel: o_out_valid / i_out_ready carry the four rotated corners,
// Q16.16, each coordinate saturated to the signed 32-bit range.
// Stages in order: angle folding and pivot offsets, one per cordic cell,
// then clamp, multiply and round/saturate stages. The row of cordic cells
// sets the depth; every stage is registered, so one box is taken per clock
// while the output is taken. When the receiver stalls, the output register
// holds its word and the stages behind it keep filling until the row is
// full; input ready drops only when every stage holds a word. Reset empties
// all stages; no word is presented until a new box comes in.
module box_corner_rotator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_top_left_x,
    input  logic [31:0] i_top_left_y,
    input  logic [31:0] i_top_right_x,
    input  logic [31:0] i_top_right_y,
    input  logic [31:0] i_bottom_right_x,
    input  logic [31:0] i_bottom_right_y,
    input  logic [31:0] i_bottom_left_x,
    input  logic [31:0] i_bottom_left_y,
    input  logic [31:0] i_pivot_x,
    input  logic [31:0] i_pivot_y,
    input  logic [19:0] i_turn_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_top_left_x,
    output logic [31:0] o_new_top_left_y,
    output logic [31:0] o_new_top_right_x,
    output logic [31:0] o_new_top_right_y,
    output logic [31:0] o_new_bottom_right_x,
    output logic [31:0] o_new_bottom_right_y,
    output logic [31:0] o_new_bottom_left_x,
    output logic [31:0] o_new_bottom_left_y
);
    import brc_pkg::*;

    logic [CORNERS-1:0][COORD_W-1:0] in_cx;
    logic [CORNERS-1:0][COORD_W-1:0] in_cy;
    logic [CORNERS-1:0][COORD_W-1:0] out_x;
    logic [CORNERS-1:0][COORD_W-1:0] out_y;

    // links of the cell row, index 0 is the prep stage output
    t_cordic link_cordic [CORDIC_STAGES+1];
    t_geom   link_geom   [CORDIC_STAGES+1];
    logic    link_valid  [CORDIC_STAGES+1];
    logic    link_ready  [CORDIC_STAGES+1];

    assign in_cx = {i_bottom_left_x, i_bottom_right_x, i_top_right_x, i_top_left_x};
    assign in_cy = {i_bottom_left_y, i_bottom_right_y, i_top_right_y, i_top_left_y};

    // angle folding and pivot offsets
    brc_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_cx     (in_cx),
        .i_cy     (in_cy),
        .i_px     (i_pivot_x),
        .i_py     (i_pivot_y),
        .i_angle  (i_turn_angle),
        .o_valid  (link_valid[0]),
        .i_ready  (link_ready[0]),
        .o_cordic (link_cordic[0]),
        .o_geom   (link_geom[0])
    );

    // row of cordic cells, one micro-rotation each
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        brc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (IDX_W'(g)),
            .i_valid  (link_valid[g]),
            .o_ready  (link_ready[g]),
            .i_cordic (link_cordic[g]),
            .i_geom   (link_geom[g]),
            .o_valid  (link_valid[g+1]),
            .i_ready  (link_ready[g+1]),
            .o_cordic (link_cordic[g+1]),
            .o_geom   (link_geom[g+1])
        );
    end

    // sine/cosine clamp, products, rounding and saturation
    brc_rotate u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (link_valid[CORDIC_STAGES]),
        .o_ready  (link_ready[CORDIC_STAGES]),
        .i_cordic (link_cordic[CORDIC_STAGES]),
        .i_geom   (link_geom[CORDIC_STAGES]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_x      (out_x),
        .o_y      (out_y)
    );

    assign o_new_top_left_x     = out_x[0];
    assign o_new_top_left_y     = out_y[0];
    assign o_new_top_right_x    = out_x[1];
    assign o_new_top_right_y    = out_y[1];
    assign o_new_bottom_right_x = out_x[2];
    assign o_new_bottom_right_y = out_y[2];
    assign o_new_bottom_left_x  = out_x[3];
    assign o_new_bottom_left_y  = out_y[3];

endmodule

FILE: design/brc_checker.sv
`include "box_corner_rotator_assert.svh"

module brc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_new_top_left_x,
    input logic [31:0] o_new_top_left_y,
    input logic [31:0] o_new_bottom_right_x,
    input logic [31:0] o_new_bottom_left_y
);

    // a stalled output word stays up
    `BRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // and keeps its top-left x/y, bottom-right x and bottom-left y coordinates
    `BRC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_new_top_left_x) && $stable(o_new_top_left_y)
        && $stable(o_new_bottom_right_x) && $stable(o_new_bottom_left_y))

    // reset empties the pipeline
    `BRC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)

    // an empty or drained output never blocks the input
    `BRC_ASSERT_SAME(a_ready_chain, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

endmodule

bind box_corner_rotator brc_checker u_brc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_new_top_left_x     (o_new_top_left_x),
    .o_new_top_left_y     (o_new_top_left_y),
    .o_new_bottom_right_x (o_new_bottom_right_x),
    .o_new_bottom_left_y  (o_new_bottom_left_y)
);
